// ----- rtl/tos_pkg.sv -----
package tos_pkg;

  localparam int ValueW = 64;
  localparam int VarW   = 6;

  typedef enum logic [3:0] {
    OP_PUSH     = 4'd0,
    OP_PUSHREF  = 4'd1,
    OP_POP      = 4'd2,
    OP_POPREF   = 4'd3,
    OP_WRITEVAR = 4'd4,
    OP_DUP      = 4'd5,
    OP_SWAP     = 4'd6,
    OP_CLEAR    = 4'd7,
    OP_PEEK     = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2,
    STS_NOTREF    = 2'd3
  } status_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_PREV = 2'd1,
    CM_NEXT = 2'd2,
    CM_LOAD = 2'd3
  } cell_mode_t;

  // One stack entry: a plain value word, or a reference to a variable.
  typedef struct packed {
    logic                     is_ref;
    logic [VarW-1:0]          var_idx;
    logic signed [ValueW-1:0] value;
  } entry_t;

endpackage

// ----- rtl/tos_if.sv -----
interface tos_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [63:0] value;
  logic [4:0]         var_index;

  modport source (output valid, func, value, var_index, input ready);
  modport sink (input valid, func, value, var_index, output ready);
endinterface

interface tos_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [4:0]         result_var;
  logic [1:0]         status;
  logic [7:0]         depth;

  modport source (output valid, result_value, result_var, status, depth, input ready);
  modport sink (input valid, result_value, result_var, status, depth, output ready);
endinterface

// ----- rtl/tos_ram.sv -----
module tos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 26
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/tos_cell.sv -----
module tos_cell
  import tos_pkg::*;
(
  input  logic       clk,
  input  cell_mode_t mode,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  input  entry_t     load_entry,
  output entry_t     entry
);

  // Take from the neighbour nearer the top on a push, from the one below on a pop.
  always_ff @(posedge clk) begin
    case (mode)
      CM_HOLD: entry <= entry;
      CM_PREV: entry <= prev_entry;
      CM_NEXT: entry <= next_entry;
      CM_LOAD: entry <= load_entry;
      default: entry <= entry;
    endcase
  end

endmodule

// ----- rtl/tagged_operand_stack_unit.sv -----
// Operand stack of tagged entries (a 64-bit value word or a reference to one
// of NUM_VARS variables) with a variable store. The stack is a chain of
// STACK_DEPTH cells: cell 0 always holds the top entry and every push or pop
// shifts the whole chain by one place, so only the two top cells are ever
// read. Each command word is handled in two steps: the first reads the variable
// store (a RAM with registered read) at the references held in the top two
// cells, the second updates the chain, the depth and the variables and loads
// the response register. A new command is taken only once the last one has
// committed; a response still waiting holds the next command in its execute
// state, and so holds off the command after it. Variables reset
// to zero through one valid bit per variable, so there is no clearing pass
// after reset. References, popped or peeked, duplicated or swapped, always
// read the variable's current value.
module tagged_operand_stack_unit
  import tos_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int NUM_VARS    = 26
) (
  input  logic clk,
  input  logic rst,
  tos_cmd_if.sink   cmd,
  tos_rsp_if.source rsp
);

  localparam int DepthW = $clog2(STACK_DEPTH + 1);
  localparam int AddrW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // Command held for the execute cycle.
  logic [3:0]         func_q;
  logic signed [63:0] value_q;
  logic [4:0]         vidx_q;

  logic [DepthW-1:0] depth, depth_next;
  logic [NUM_VARS-1:0] var_valid;
  logic vld_a, vld_b;

  entry_t chain [STACK_DEPTH];
  entry_t load0, load1;
  cell_mode_t mode0, mode1, mode_rest;
  cell_mode_t op_mode0, op_mode1, op_mode_rest;

  logic signed [63:0] rdata_a, rdata_b;
  logic signed [63:0] top_a, top_b;
  logic signed [63:0] res_val;
  logic [4:0]         res_var;
  status_t            sts;
  logic               var_we;
  logic               commit;
  logic               empty, full, two_or_more, vidx_ok;

  logic signed [63:0] rsp_value;
  logic [4:0]         rsp_var;
  logic [1:0]         rsp_status;
  logic [7:0]         rsp_depth;
  logic               rsp_valid;

  // ---------------------------------------------------------------------
  // Handshake and sequencing
  // ---------------------------------------------------------------------
  assign cmd.ready = (state == S_IDLE);
  // Execute only once the response register is free or being drained.
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (cmd.valid) state <= S_EXEC;
        S_EXEC: if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      func_q  <= cmd.func;
      value_q <= cmd.value;
      vidx_q  <= cmd.var_index;
    end
  end

  // ---------------------------------------------------------------------
  // Variable store: read at the references of the top two cells
  // ---------------------------------------------------------------------
  tos_ram #(
    .WIDTH(ValueW),
    .DEPTH(NUM_VARS)
  ) u_vars (
    .clk    (clk),
    .we     (var_we),
    .waddr  (AddrW'(vidx_q)),
    .wdata  (value_q),
    .raddr_a(chain[0].var_idx[AddrW-1:0]),
    .raddr_b(chain[1].var_idx[AddrW-1:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // Track written variables; an unwritten one reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      var_valid <= '0;
    end else if (var_we) begin
      var_valid[AddrW'(vidx_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_a <= var_valid[chain[0].var_idx[AddrW-1:0]];
    vld_b <= var_valid[chain[1].var_idx[AddrW-1:0]];
  end

  // Dereferenced top two entries.
  assign top_a = chain[0].is_ref ? (vld_a ? rdata_a : '0) : chain[0].value;
  assign top_b = chain[1].is_ref ? (vld_b ? rdata_b : '0) : chain[1].value;

  // ---------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------
  assign empty       = (depth == '0);
  assign full        = (depth == DepthW'(STACK_DEPTH));
  assign two_or_more = (depth >= DepthW'(2));
  assign vidx_ok     = (32'(vidx_q) < 32'(NUM_VARS));

  always_comb begin
    op_mode0     = CM_HOLD;
    op_mode1     = CM_HOLD;
    op_mode_rest = CM_HOLD;
    load0        = '0;
    load1        = '0;
    depth_next   = depth;
    res_val      = '0;
    res_var      = '0;
    sts          = STS_OK;
    var_we       = 1'b0;
    case (op_t'(func_q))
      OP_PUSH: begin
        if (full) begin
          sts = STS_OVERFLOW;
        end else begin
          load0.value  = value_q;
          op_mode0     = CM_LOAD;
          op_mode1     = CM_PREV;
          op_mode_rest = CM_PREV;
          depth_next   = depth + DepthW'(1);
        end
      end
      OP_PUSHREF: begin
        // Drop a reference to a variable that does not exist.
        if (vidx_ok) begin
          if (full) begin
            sts = STS_OVERFLOW;
          end else begin
            load0.is_ref  = 1'b1;
            load0.var_idx = {1'b0, vidx_q};
            op_mode0      = CM_LOAD;
            op_mode1      = CM_PREV;
            op_mode_rest  = CM_PREV;
            depth_next    = depth + DepthW'(1);
          end
        end
      end
      OP_POP: begin
        if (empty) begin
          sts = STS_UNDERFLOW;
        end else begin
          res_val      = top_a;
          op_mode0     = CM_NEXT;
          op_mode1     = CM_NEXT;
          op_mode_rest = CM_NEXT;
          depth_next   = depth - DepthW'(1);
        end
      end
      OP_POPREF: begin
        if (empty) begin
          sts = STS_UNDERFLOW;
        end else if (!chain[0].is_ref) begin
          sts = STS_NOTREF;
        end else begin
          res_var      = chain[0].var_idx[4:0];
          op_mode0     = CM_NEXT;
          op_mode1     = CM_NEXT;
          op_mode_rest = CM_NEXT;
          depth_next   = depth - DepthW'(1);
        end
      end
      OP_WRITEVAR: begin
        var_we = vidx_ok && commit;
      end
      OP_DUP: begin
        if (empty) begin
          sts = STS_UNDERFLOW;
        end else if (full) begin
          sts = STS_OVERFLOW;
        end else begin
          // Old top becomes its value; a copy goes on top of it.
          load0.value  = top_a;
          load1.value  = top_a;
          op_mode0     = CM_LOAD;
          op_mode1     = CM_LOAD;
          op_mode_rest = CM_PREV;
          depth_next   = depth + DepthW'(1);
        end
      end
      OP_SWAP: begin
        if (!two_or_more) begin
          sts = STS_UNDERFLOW;
        end else begin
          load0.value = top_b;
          load1.value = top_a;
          op_mode0    = CM_LOAD;
          op_mode1    = CM_LOAD;
        end
      end
      OP_CLEAR: begin
        depth_next = '0;
      end
      OP_PEEK: begin
        if (empty) begin
          sts = STS_UNDERFLOW;
        end else begin
          res_val = top_a;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the chain unless the command commits this cycle.
  assign mode0     = commit ? op_mode0 : CM_HOLD;
  assign mode1     = commit ? op_mode1 : CM_HOLD;
  assign mode_rest = commit ? op_mode_rest : CM_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (commit) begin
      depth <= depth_next;
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: cell 0 is the top of stack
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e, load_e;
    cell_mode_t mode_e;

    if (i == 0) begin : g_top
      assign prev_e = load0;
      assign load_e = load0;
      assign mode_e = mode0;
    end else if (i == 1) begin : g_second
      assign prev_e = chain[i-1];
      assign load_e = load1;
      assign mode_e = mode1;
    end else begin : g_lower
      assign prev_e = chain[i-1];
      assign load_e = chain[i-1];
      assign mode_e = mode_rest;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_e = chain[i];
    end else begin : g_inner
      assign next_e = chain[i+1];
    end

    tos_cell u_cell (
      .clk       (clk),
      .mode      (mode_e),
      .prev_entry(prev_e),
      .next_entry(next_e),
      .load_entry(load_e),
      .entry     (chain[i])
    );
  end

  // ---------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_value  <= res_val;
      rsp_var    <= res_var;
      rsp_status <= sts;
      rsp_depth  <= 8'(depth_next);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign rsp.result_var   = rsp_var;
  assign rsp.status       = rsp_status;
  assign rsp.depth        = rsp_depth;

endmodule

// ----- tb/tb_tagged_operand_stack_unit.sv -----
module tb_tagged_operand_stack_unit
  import tos_pkg::*;
();

  localparam int STACK_DEPTH = 128;
  localparam int NUM_VARS    = 26;

  // Codes outside the operation set; the block must treat them as a no-op.
  localparam logic [3:0] FUNC_UNUSED_LO = 4'd9;
  localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PATTERN  = 64'h0123_4567_89AB_CDEF;

  localparam int NUM_RANDOM     = 1000;
  localparam int HOLD_LEN       = 300;   // long receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 10;

  // One reply word as the block should deliver it.
  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  var_idx;
    status_t     status;
    logic [7:0]  depth;
  } stack_reply_t;

  // One row of the directed script. Rows marked typed carry their reply;
  // the rest take the reply from the stack predictor.
  typedef struct packed {
    logic [3:0]   func;
    logic [63:0]  value;
    logic [4:0]   var_index;
    logic         typed;
    stack_reply_t reply;
  } script_row_t;

  logic clk;
  logic rst;

  tos_cmd_if cmd_if ();
  tos_rsp_if rsp_if ();

  tagged_operand_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .NUM_VARS   (NUM_VARS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  // Predicted contents of the block: entry words, entry tags (0 for a plain
  // value, otherwise variable number + 1), the variable store and the depth.
  logic [63:0] entry_word [STACK_DEPTH];
  logic [5:0]  entry_tag  [STACK_DEPTH];
  logic [63:0] var_word   [NUM_VARS];
  int          cur_depth;

  stack_reply_t replies_due[$];
  script_row_t  script[$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  bit growing;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Dereference an entry: a reference yields its variable's current value.
  function automatic logic [63:0] entry_deref(input int pos);
    if (entry_tag[pos] == 6'd0) return entry_word[pos];
    if (entry_tag[pos] - 6'd1 < NUM_VARS) return var_word[entry_tag[pos] - 6'd1];
    return 64'd0;
  endfunction

  // Apply one command word to the predicted stack and work out its reply.
  task automatic predict_op(input logic [3:0] func, input logic [63:0] value,
                            input logic [4:0] var_index, output stack_reply_t reply);
    logic [63:0] top_val;
    logic [63:0] next_val;
    reply = '0;
    reply.status = STS_OK;
    case (func)
      OP_PUSH: begin
        if (cur_depth >= STACK_DEPTH) begin
          reply.status = STS_OVERFLOW;
        end else begin
          entry_word[cur_depth] = value;
          entry_tag[cur_depth]  = 6'd0;
          cur_depth++;
        end
      end
      OP_PUSHREF: begin
        // An out-of-range variable is dropped silently, even on a full stack.
        if (var_index < NUM_VARS) begin
          if (cur_depth >= STACK_DEPTH) begin
            reply.status = STS_OVERFLOW;
          end else begin
            entry_word[cur_depth] = 64'd0;
            entry_tag[cur_depth]  = 6'(var_index) + 6'd1;
            cur_depth++;
          end
        end
      end
      OP_POP: begin
        if (cur_depth == 0) begin
          reply.status = STS_UNDERFLOW;
        end else begin
          reply.value = entry_deref(cur_depth - 1);
          cur_depth--;
        end
      end
      OP_POPREF: begin
        if (cur_depth == 0) begin
          reply.status = STS_UNDERFLOW;
        end else if (entry_tag[cur_depth - 1] == 6'd0) begin
          reply.status = STS_NOTREF;
        end else begin
          reply.var_idx = 5'(entry_tag[cur_depth - 1] - 6'd1);
          cur_depth--;
        end
      end
      OP_WRITEVAR: begin
        if (var_index < NUM_VARS) var_word[var_index] = value;
      end
      OP_DUP: begin
        if (cur_depth == 0) begin
          reply.status = STS_UNDERFLOW;
        end else if (cur_depth >= STACK_DEPTH) begin
          reply.status = STS_OVERFLOW;
        end else begin
          // The top turns into a plain value and a copy lands above it.
          top_val = entry_deref(cur_depth - 1);
          entry_word[cur_depth - 1] = top_val;
          entry_tag[cur_depth - 1]  = 6'd0;
          entry_word[cur_depth]     = top_val;
          entry_tag[cur_depth]      = 6'd0;
          cur_depth++;
        end
      end
      OP_SWAP: begin
        if (cur_depth < 2) begin
          reply.status = STS_UNDERFLOW;
        end else begin
          top_val  = entry_deref(cur_depth - 1);
          next_val = entry_deref(cur_depth - 2);
          entry_word[cur_depth - 2] = top_val;
          entry_tag[cur_depth - 2]  = 6'd0;
          entry_word[cur_depth - 1] = next_val;
          entry_tag[cur_depth - 1]  = 6'd0;
        end
      end
      OP_CLEAR: cur_depth = 0;
      OP_PEEK: begin
        if (cur_depth == 0) reply.status = STS_UNDERFLOW;
        else reply.value = entry_deref(cur_depth - 1);
      end
      default: ;
    endcase
    reply.depth = 8'(cur_depth);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h (%0d replies still due)",
             field, got, want, replies_due.size());
    fail_count++;
  endtask

  task automatic add_row(input logic [3:0] func, input logic [63:0] value,
                         input logic [4:0] var_index, input logic typed,
                         input logic [63:0] r_value, input logic [4:0] r_var,
                         input status_t r_status, input logic [7:0] r_depth);
    script_row_t row;
    row.func          = func;
    row.value         = value;
    row.var_index     = var_index;
    row.typed         = typed;
    row.reply.value   = r_value;
    row.reply.var_idx = r_var;
    row.reply.status  = r_status;
    row.reply.depth   = r_depth;
    script.push_back(row);
  endtask

  // Offer one command word and hold it until the block takes it. Idle
  // cycles go in front of the word, so valid never drops while a word is
  // on offer. Return at the accepting edge with valid still high.
  task automatic send_word(input logic [3:0] func, input logic [63:0] value,
                           input logic [4:0] var_index, input logic typed,
                           input stack_reply_t typed_reply);
    stack_reply_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.func      <= func;
    cmd_if.value     <= value;
    cmd_if.var_index <= var_index;
    @(posedge clk);
    while (!(cmd_if.valid && cmd_if.ready)) @(posedge clk);
    predict_op(func, value, var_index, predicted);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  // Pick a random word. The stream alternates between a growing spell that
  // pushes the stack up to full and a shrinking spell that brings it back
  // to empty, so both overflow and underflow are hit over and over.
  task automatic next_random_word(output logic [3:0] func, output logic [63:0] value,
                                  output logic [4:0] var_index);
    int roll;
    roll = $urandom_range(0, 99);
    if (growing && cur_depth == STACK_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if (!growing && cur_depth == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;

    if (roll < 2)       func = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    else if (growing) begin
      if (roll < 40)      func = OP_PUSH;
      else if (roll < 58) func = OP_PUSHREF;
      else if (roll < 72) func = OP_DUP;
      else if (roll < 80) func = OP_WRITEVAR;
      else if (roll < 85) func = OP_SWAP;
      else if (roll < 89) func = OP_PEEK;
      else if (roll < 95) func = OP_POP;
      else                func = OP_POPREF;
    end else begin
      if (roll < 42)      func = OP_POP;
      else if (roll < 62) func = OP_POPREF;
      else if (roll < 68) func = OP_SWAP;
      else if (roll < 74) func = OP_PEEK;
      else if (roll < 82) func = OP_WRITEVAR;
      else if (roll < 87) func = OP_DUP;
      else if (roll < 92) func = OP_PUSH;
      else if (roll < 96) func = OP_PUSHREF;
      else if (roll < 97) func = OP_CLEAR;
      else                func = OP_PEEK;
    end

    case ($urandom_range(0, 7))
      0:       value = MAX_POS;
      1:       value = MIN_NEG;
      2:       value = ALL_ONES;
      3:       value = 64'd0;
      default: value = {$urandom, $urandom};
    endcase

    // Mostly real variables; now and then a number past the last one.
    if ($urandom_range(0, 9) == 0) var_index = 5'($urandom_range(NUM_VARS, 31));
    else                           var_index = 5'($urandom_range(0, NUM_VARS - 1));
  endtask

  // Receiver: random back-pressure, plus the long hold-off on request. The
  // hold-off is counted here so the sender keeps offering words meanwhile.
  int hold_left;
  bit hold_taken;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
    end else begin
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_LEN;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare every reply word taken with the oldest reply still due.
  always @(posedge clk) begin : check_replies
    stack_reply_t due;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none due, result_value", rsp_if.result_value, 64'd0);
      end else begin
        due = replies_due.pop_front();
        if (rsp_if.result_value !== due.value)
          report_mismatch("result_value", rsp_if.result_value, due.value);
        if (rsp_if.result_var !== due.var_idx)
          report_mismatch("result_var", 64'(rsp_if.result_var), 64'(due.var_idx));
        if (rsp_if.status !== due.status)
          report_mismatch("status", 64'(rsp_if.status), 64'(due.status));
        if (rsp_if.depth !== due.depth)
          report_mismatch("depth", 64'(rsp_if.depth), 64'(due.depth));
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d replies still due",
                 idle_cycles, replies_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [3:0]   func;
    logic [63:0]  value;
    logic [4:0]   var_index;
    stack_reply_t no_reply;

    no_reply         = '0;
    cur_depth        = 0;
    growing          = 1'b1;
    hold_request     = 1'b0;
    send_idle_pct    = 11;
    recv_idle_pct    = 49;
    for (int i = 0; i < NUM_VARS; i++) var_word[i] = 64'd0;

    rst              = 1'b1;
    cmd_if.valid     = 1'b0;
    cmd_if.func      = OP_PUSH;
    cmd_if.value     = 64'd0;
    cmd_if.var_index = 5'd0;

    // Directed script: every error on the empty stack, the value and
    // variable extremes, out-of-range variables, a reference that must read
    // its variable's later value, a swap with a reference, unused codes.
    add_row(OP_POP,      64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd0);
    add_row(OP_PEEK,     64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd0);
    add_row(OP_POPREF,   64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd0);
    add_row(OP_DUP,      64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd0);
    add_row(OP_SWAP,     64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd0);
    add_row(OP_WRITEVAR, ALL_ONES, 5'd25, 1'b1, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_WRITEVAR, MIN_NEG,  5'd0,  1'b1, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_WRITEVAR, MAX_POS,  5'd31, 1'b1, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_PUSHREF,  64'd0,    5'd26, 1'b1, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_PUSH,     MAX_POS,  5'd0,  1'b1, 64'd0,    5'd0, STS_OK,        8'd1);
    add_row(OP_SWAP,     64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_UNDERFLOW, 8'd1);
    add_row(OP_POPREF,   64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_NOTREF,    8'd1);
    add_row(OP_PUSHREF,  64'd0,    5'd25, 1'b1, 64'd0,    5'd0, STS_OK,        8'd2);
    add_row(OP_PEEK,     64'd0,    5'd0,  1'b1, ALL_ONES, 5'd0, STS_OK,        8'd2);
    add_row(OP_WRITEVAR, PATTERN,  5'd25, 1'b1, 64'd0,    5'd0, STS_OK,        8'd2);
    add_row(OP_PEEK,     64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_SWAP,     64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_PUSH,     MIN_NEG,  5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_DUP,      64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_POPREF,   64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_PUSHREF,  64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_POPREF,   64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(OP_POP,      64'd0,    5'd0,  1'b0, 64'd0,    5'd0, STS_OK,        8'd0);
    add_row(FUNC_UNUSED_LO, ALL_ONES, 5'd31, 1'b0, 64'd0, 5'd0, STS_OK,        8'd0);
    add_row(FUNC_UNUSED_HI, ALL_ONES, 5'd31, 1'b0, 64'd0, 5'd0, STS_OK,        8'd0);
    add_row(OP_CLEAR,    64'd0,    5'd0,  1'b1, 64'd0,    5'd0, STS_OK,        8'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_word(script[i].func, script[i].value, script[i].var_index,
                script[i].typed, script[i].reply);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        // Swap the idling sides and hold the receiver off for a long spell,
        // so the block fills up and stalls its command side.
        send_idle_pct = 49;
        recv_idle_pct = 11;
        hold_request  = 1'b1;
      end else if (i == 2 * NUM_RANDOM / 3) begin
        // Pause until every reply is home, then run flat out.
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0) @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      next_random_word(func, value, var_index);
      send_word(func, value, var_index, 1'b0, no_reply);
    end

    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
